// ----- hw/rtl/srg_pkg.sv -----
// Shared types, codes and neighbor tables for the seeded region grower.
package srg_pkg;

  // Default store geometry
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field and register widths
  localparam int REQ_W    = 2;
  localparam int POS_W    = 8;
  localparam int GRAY_W   = 8;
  localparam int TOL_W    = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W    = 9;
  localparam int BPP_W    = 3;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GROW   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_SEED_OUT = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_FMT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPP   = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] IMG_W_RESET = 9'd256;
  localparam logic [DIM_W-1:0] IMG_H_RESET = 9'd256;
  localparam logic [BPP_W-1:0] BPP_RESET   = 3'd1;
  localparam logic [BPP_W-1:0] BPP_ONE     = 3'd1;

  // One coordinate step of a neighbor: +1, -1 or none
  typedef struct packed {
    logic inc;
    logic dec;
  } step_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic req_cap;   // accept a request word
    logic load_wr;   // write a pixel
    logic mask_rd;   // read mask bit at request position
    logic rd_done;   // capture read result
    logic clr_step;  // clear one mask entry
    logic seed_rd;   // read seed pixel
    logic seed_wr;   // mark seed, push it
    logic pop;       // pop stack top
    logic pop_load;  // load popped pixel as current
    logic nb_rd;     // read neighbor mask and pixel
    logic nb_skip;   // step past neighbor outside image
    logic nb_wr;     // join neighbor if it qualifies, next neighbor
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [REQ_W-1:0] in_type;
    logic grow_ok;
    logic clr_last;
    logic depth_zero;
    logic k_last;
    logic nb_ok;
  } sts_t;

  // 8-connected neighbor order, column step
  function automatic step_t nb_x_step(input logic [2:0] k);
    step_t s;
    s = '0;
    unique case (k)
      3'd1, 3'd2, 3'd3: s.inc = 1'b1;
      3'd5, 3'd6, 3'd7: s.dec = 1'b1;
      default: s = '0;
    endcase
    return s;
  endfunction

  // 8-connected neighbor order, row step
  function automatic step_t nb_y_step(input logic [2:0] k);
    step_t s;
    s = '0;
    unique case (k)
      3'd0, 3'd1, 3'd7: s.inc = 1'b1;
      3'd3, 3'd4, 3'd5: s.dec = 1'b1;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/srg_if.sv -----
// Request and result channel interfaces for the seeded region grower.
interface srg_in_if;
  logic                           valid;
  logic                           ready;
  logic [srg_pkg::REQ_W-1:0]      req_type;
  logic [srg_pkg::POS_W-1:0]      pos_x;
  logic [srg_pkg::POS_W-1:0]      pos_y;
  logic [srg_pkg::GRAY_W-1:0]     gray_value;
  logic [srg_pkg::TOL_W-1:0]      tolerance;

  modport source (output valid, req_type, pos_x, pos_y, gray_value, tolerance, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, gray_value, tolerance, output ready);
endinterface

interface srg_out_if;
  logic                           valid;
  logic                           ready;
  logic                           in_region;
  logic [srg_pkg::STATUS_W-1:0]   status;

  modport source (output valid, in_region, status, input ready);
  modport sink (input valid, in_region, status, output ready);
endinterface

// ----- hw/rtl/srg_datapath.sv -----
// Datapath: image, mask and stack memories, config registers, neighbor logic.
module srg_datapath #(
  parameter int MAX_WIDTH  = srg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = srg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [srg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [srg_pkg::REQ_W-1:0]       req_type,
  input  logic [srg_pkg::POS_W-1:0]       pos_x,
  input  logic [srg_pkg::POS_W-1:0]       pos_y,
  input  logic [srg_pkg::GRAY_W-1:0]      gray_value,
  input  logic [srg_pkg::TOL_W-1:0]       tolerance,
  input  srg_pkg::cmd_t                   cmd,
  output srg_pkg::sts_t                   sts,
  output logic                            res_in_region,
  output logic [srg_pkg::STATUS_W-1:0]    res_status
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CXW   = $clog2(MAX_WIDTH + 1);
  localparam int CYW   = $clog2(MAX_HEIGHT + 1);
  localparam int BWX   = (CXW > srg_pkg::DIM_W) ? CXW : srg_pkg::DIM_W;
  localparam int BWY   = (CYW > srg_pkg::DIM_W) ? CYW : srg_pkg::DIM_W;

  // Memories
  logic [srg_pkg::GRAY_W-1:0] img_mem [DEPTH];
  logic                       mask_mem [DEPTH];
  logic [AW-1:0]              stk_mem [DEPTH];

  // Config registers
  logic [srg_pkg::DIM_W-1:0] img_w_r;
  logic [srg_pkg::DIM_W-1:0] img_h_r;
  logic [srg_pkg::BPP_W-1:0] bpp_r;

  // Request and fill state
  logic [srg_pkg::POS_W-1:0]    req_x_r, req_y_r;
  logic [srg_pkg::TOL_W-1:0]    tol_r;
  logic                         rd_inside_r;
  logic [srg_pkg::GRAY_W-1:0]   seed_gray_r;
  logic [AW:0]                  depth_r;
  logic [AW-1:0]                clr_r;
  logic [2:0]                   k_r;
  logic [XW-1:0]                cur_x_r;
  logic [YW-1:0]                cur_y_r;
  logic                         out_region_r;
  logic [srg_pkg::STATUS_W-1:0] out_status_r;

  // Registered memory read data
  logic [srg_pkg::GRAY_W-1:0] img_q;
  logic                       mask_q;
  logic [AW-1:0]              stk_q;

  logic [BWX-1:0] w_cfg, w_max, w_eff;
  logic [BWY-1:0] h_cfg, h_max, h_eff;
  logic           in_store, in_image;
  logic [AW-1:0]  in_addr, seed_addr, nb_addr, pop_idx;
  srg_pkg::step_t sx, sy;
  logic [BWX-1:0] nx;
  logic [BWY-1:0] ny;
  logic           nb_ok;
  logic [srg_pkg::GRAY_W-1:0] diff;
  logic           join_nb;
  logic [srg_pkg::STATUS_W-1:0] grow_sts;

  // Clamp configured size to the store
  assign w_cfg = BWX'(img_w_r);
  assign h_cfg = BWY'(img_h_r);
  assign w_max = BWX'(MAX_WIDTH);
  assign h_max = BWY'(MAX_HEIGHT);
  assign w_eff = (w_cfg > w_max) ? w_max : w_cfg;
  assign h_eff = (h_cfg > h_max) ? h_max : h_cfg;

  // Request position checks
  assign in_store = (BWX'(pos_x) < w_max) && (BWY'(pos_y) < h_max);
  assign in_image = (BWX'(pos_x) < w_eff) && (BWY'(pos_y) < h_eff);
  assign in_addr  = {YW'(pos_y), XW'(pos_x)};
  assign seed_addr = {YW'(req_y_r), XW'(req_x_r)};

  always_comb begin
    if (bpp_r != srg_pkg::BPP_ONE) begin
      grow_sts = srg_pkg::STS_BAD_FMT;
    end else if (!in_image) begin
      grow_sts = srg_pkg::STS_SEED_OUT;
    end else begin
      grow_sts = srg_pkg::STS_OK;
    end
  end

  // Neighbor address and bounds
  assign sx = srg_pkg::nb_x_step(k_r);
  assign sy = srg_pkg::nb_y_step(k_r);

  always_comb begin
    nx = BWX'(cur_x_r);
    ny = BWY'(cur_y_r);
    if (sx.inc) nx = BWX'(cur_x_r) + BWX'(1);
    if (sx.dec) nx = BWX'(cur_x_r) - BWX'(1);
    if (sy.inc) ny = BWY'(cur_y_r) + BWY'(1);
    if (sy.dec) ny = BWY'(cur_y_r) - BWY'(1);
  end

  assign nb_ok = !(sx.dec && (cur_x_r == '0)) && !(sy.dec && (cur_y_r == '0)) &&
                 (nx < w_eff) && (ny < h_eff);
  assign nb_addr = {ny[YW-1:0], nx[XW-1:0]};
  assign pop_idx = AW'(depth_r - (AW+1)'(1));

  // Join test against the seed gray level
  assign diff    = (img_q > seed_gray_r) ? (img_q - seed_gray_r) : (seed_gray_r - img_q);
  assign join_nb = !mask_q && ({1'b0, diff} < tol_r);

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= srg_pkg::IMG_W_RESET;
      img_h_r <= srg_pkg::IMG_H_RESET;
      bpp_r   <= srg_pkg::BPP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srg_pkg::REG_IMG_W: img_w_r <= cfg_wdata;
        srg_pkg::REG_IMG_H: img_h_r <= cfg_wdata;
        srg_pkg::REG_BPP:   bpp_r   <= cfg_wdata[srg_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Image memory
  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_store) img_mem[in_addr] <= gray_value;
    if (cmd.seed_rd || cmd.nb_rd) img_q <= img_mem[cmd.seed_rd ? seed_addr : nb_addr];
  end

  // Mask memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mask_mem[clr_r] <= 1'b0;
    end else if (cmd.seed_wr) begin
      mask_mem[seed_addr] <= 1'b1;
    end else if (cmd.nb_wr && join_nb) begin
      mask_mem[nb_addr] <= 1'b1;
    end
    if (cmd.mask_rd || cmd.nb_rd) mask_q <= mask_mem[cmd.mask_rd ? in_addr : nb_addr];
  end

  // Pending stack memory
  always_ff @(posedge clk) begin
    if (cmd.seed_wr) begin
      stk_mem['0] <= seed_addr;
    end else if (cmd.nb_wr && join_nb) begin
      stk_mem[depth_r[AW-1:0]] <= nb_addr;
    end
    stk_q <= stk_mem[pop_idx];
  end

  // Fill control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      clr_r       <= '0;
      k_r         <= '0;
      seed_gray_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      if (cmd.seed_wr) begin
        seed_gray_r <= img_q;
        depth_r     <= (AW+1)'(1);
      end else if (cmd.pop) begin
        depth_r <= depth_r - (AW+1)'(1);
      end else if (cmd.nb_wr && join_nb) begin
        depth_r <= depth_r + (AW+1)'(1);
      end
      if (cmd.pop_load) begin
        k_r <= '0;
      end else if (cmd.nb_wr || cmd.nb_skip) begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  // Request capture, current pixel and result word
  always_ff @(posedge clk) begin
    if (cmd.req_cap) begin
      req_x_r      <= pos_x;
      req_y_r      <= pos_y;
      tol_r        <= tolerance;
      rd_inside_r  <= in_store;
      out_region_r <= 1'b0;
      out_status_r <= (req_type == srg_pkg::REQ_GROW) ? grow_sts : srg_pkg::STS_OK;
    end
    if (cmd.rd_done) out_region_r <= rd_inside_r & mask_q;
    if (cmd.pop_load) begin
      cur_x_r <= stk_q[XW-1:0];
      cur_y_r <= stk_q[AW-1:XW];
    end
  end

  assign sts.in_type    = req_type;
  assign sts.grow_ok    = (grow_sts == srg_pkg::STS_OK);
  assign sts.clr_last   = (clr_r == AW'(DEPTH - 1));
  assign sts.depth_zero = (depth_r == '0);
  assign sts.k_last     = (k_r == 3'd7);
  assign sts.nb_ok      = nb_ok;

  assign res_in_region = out_region_r;
  assign res_status    = out_status_r;

endmodule

// ----- hw/rtl/srg_ctrl.sv -----
// Controller: sequences requests, mask clearing and the stack-driven fill.
module srg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  srg_pkg::sts_t sts,
  output srg_pkg::cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_SEED  = 4'd4;
  localparam logic [3:0] S_SEEDW = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_POPW  = 4'd7;
  localparam logic [3:0] S_NB    = 4'd8;
  localparam logic [3:0] S_NBW   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      // mask clearing pass after reset
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_cap = 1'b1;
          priority if (sts.in_type == srg_pkg::REQ_LOAD) begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_OUT;
          end else if (sts.in_type == srg_pkg::REQ_READ) begin
            cmd.mask_rd = 1'b1;
            state_nxt   = S_RD;
          end else if (sts.in_type == srg_pkg::REQ_GROW && sts.grow_ok) begin
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD: begin
        cmd.rd_done = 1'b1;
        state_nxt   = S_OUT;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed_rd = 1'b1;
        state_nxt   = S_SEEDW;
      end
      S_SEEDW: begin
        cmd.seed_wr = 1'b1;
        state_nxt   = S_POP;
      end
      S_POP: begin
        if (sts.depth_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_NB;
      end
      // test one neighbor per visit
      S_NB: begin
        if (sts.nb_ok) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NBW;
        end else begin
          cmd.nb_skip = 1'b1;
          state_nxt   = sts.k_last ? S_POP : S_NB;
        end
      end
      S_NBW: begin
        cmd.nb_wr = 1'b1;
        state_nxt = sts.k_last ? S_POP : S_NB;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/seeded_region_growing.sv -----
// Load and read: one word in flight at a time, each held until its result is taken.
// Grow: clears the whole mask, marks and pushes the seed, then pops each pixel and tests
// its eight neighbors, all through single-port reads of the image, mask and stack memories.
// Reset is synchronous, active low; after reset a mask clearing pass over all 2^AW entries
// (65536 at the default size) runs before the first request word is accepted.
module seeded_region_growing #(
  parameter int MAX_WIDTH  = srg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = srg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [srg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  srg_in_if.sink                          in_ch,
  srg_out_if.source                       out_ch
);

  srg_pkg::cmd_t cmd;
  srg_pkg::sts_t sts;

  srg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .req_type      (in_ch.req_type),
    .pos_x         (in_ch.pos_x),
    .pos_y         (in_ch.pos_y),
    .gray_value    (in_ch.gray_value),
    .tolerance     (in_ch.tolerance),
    .cmd           (cmd),
    .sts           (sts),
    .res_in_region (out_ch.in_region),
    .res_status    (out_ch.status)
  );

endmodule

// ----- hw/rtl/srg_checker.sv -----
// Port-level checker for the seeded region grower, bound to the top level.
module srg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_in_region,
  input logic [srg_pkg::STATUS_W-1:0]  out_status
);

  // no new word while a result is pending
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request accepted while result pending");

  // one word in flight: ready drops after an accept
  a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second word accepted");

  // each result is delivered once
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");

  // an error status never carries a region bit
  a_err_no_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != srg_pkg::STS_OK)) |-> !out_in_region)
    else $error("region bit with error status");

endmodule

bind seeded_region_growing srg_checker u_srg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_in_region (out_ch.in_region),
  .out_status    (out_ch.status)
);
